// ===== rtl/mcws_pkg.sv =====
package mcws_pkg;

    typedef logic [31:0] word_t;

    // Defaults for the top-level parameters.
    localparam int unsigned NUM_CLIENTS_DEF  = 3;
    localparam int unsigned TICK_RATE_HZ_DEF = 1000;

    // Limit registers exist for the largest supported client count.
    localparam int unsigned NUM_LIMITS = 3;
    localparam int unsigned MS_PER_S   = 1000;
    localparam int unsigned PADDR_W    = 4;

    // Request commands.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CHECKIN = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LIMIT_0 = 2'd0;
    localparam logic [1:0] REG_LIMIT_1 = 2'd1;
    localparam logic [1:0] REG_LIMIT_2 = 2'd2;
    localparam logic [1:0] REG_HW_WDT  = 2'd3;

    localparam logic [1:0]  NO_LATE     = 2'd3;
    localparam word_t       LIMIT_RESET = 32'd1000;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic tick;
        logic load;
        logic shift;
    } cell_ctrl_t;

    // One result as it moves along the row of cells toward the output.
    typedef struct packed {
        word_t silence;
        word_t worst;
        logic  over;
    } slot_t;

endpackage

// ===== rtl/multi_client_watchdog_supervisor_top.sv =====
// Watchdog supervisor for up to three clients. Each request is a tick advance,
// a client check-in or a periodic check. Ticks and check-ins return nothing. A
// check loads one result per client into a row of cells at once; the results
// then move one cell per accepted output toward the result port, client zero
// first, and no new request is taken until the last of them is accepted. The
// next request is taken in the same cycle as the last result of a check. The
// final result of each check carries the kick decision; once a client is found
// late, kicking stays off until reset.
// Registers on the APB port: limit for clients 0 to 2 at 0x0, 0x4, 0x8, and
// the hardware watchdog running flag at 0xC.
module multi_client_watchdog_supervisor_top #(
    parameter int unsigned NUM_CLIENTS  = mcws_pkg::NUM_CLIENTS_DEF,
    parameter int unsigned TICK_RATE_HZ = mcws_pkg::TICK_RATE_HZ_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [1:0]                   s_client_index,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_client_id,
    output logic [31:0]                  m_silence_ms,
    output logic [31:0]                  m_worst_ms,
    output logic                         m_over_limit,
    output logic                         m_kick,
    output logic                         m_report_late,
    output logic [1:0]                   m_late_client,
    output logic [31:0]                  m_late_ms,
    output logic                         m_kicking_on,
    output logic [31:0]                  m_kick_total,
    output logic                         m_last_of_run,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcws_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned CNT_W = $clog2(NUM_CLIENTS + 1);

    mcws_pkg::word_t [mcws_pkg::NUM_LIMITS-1:0] limit;
    logic                                        hw_wdt_running;

    mcws_pkg::cell_ctrl_t       ctrl;
    mcws_pkg::slot_t            chain [NUM_CLIENTS+1];
    mcws_pkg::slot_t            head;
    logic [NUM_CLIENTS-1:0]     checkin;

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [1:0]                 id_reg, id_next;
    logic                       late_seen_reg, late_seen_next;
    logic [1:0]                 late_id_reg, late_id_next;
    mcws_pkg::word_t            late_ms_reg, late_ms_next;
    logic                       kicking_en_reg, kicking_en_next;
    mcws_pkg::word_t            kick_cnt_reg, kick_cnt_next;

    logic                       in_acc;
    logic                       out_acc;
    logic                       busy;
    logic                       last;
    logic                       do_check;
    logic                       head_late;
    logic                       late_any;
    logic [1:0]                 late_id;
    mcws_pkg::word_t            late_val;
    logic                       kick_now;

    mcws_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .limit          (limit),
        .hw_wdt_running (hw_wdt_running)
    );

    assign busy    = (cnt_reg != '0);
    assign last    = (cnt_reg == CNT_W'(1));
    assign m_valid = busy;
    assign out_acc = m_valid && m_ready;
    assign s_ready = !busy || (out_acc && last);
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        ctrl.tick = 1'b0;
        do_check  = 1'b0;
        if (in_acc) begin
            unique case (s_cmd)
                mcws_pkg::CMD_TICK:    ctrl.tick = 1'b1;
                mcws_pkg::CMD_CHECKIN: ctrl.tick = 1'b0;
                mcws_pkg::CMD_CHECK:   do_check  = 1'b1;
                mcws_pkg::CMD_NONE:    ctrl.tick = 1'b0;
            endcase
        end
        ctrl.load  = do_check;
        ctrl.shift = out_acc;
    end

    assign chain[NUM_CLIENTS] = '0;

    for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_cell
        assign checkin[g] = in_acc && (s_cmd == mcws_pkg::CMD_CHECKIN)
                            && (s_client_index == 2'(g));

        mcws_cell #(
            .TICK_RATE_HZ (TICK_RATE_HZ)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .checkin  (checkin[g]),
            .limit    (limit[g]),
            .slot_in  (chain[g+1]),
            .slot_out (chain[g])
        );
    end

    assign head = chain[0];

    // First late client of this check, including the result now at the head.
    assign head_late = !late_seen_reg && head.over;
    assign late_any  = late_seen_reg || head.over;
    assign late_id   = late_seen_reg ? late_id_reg : id_reg;
    assign late_val  = late_seen_reg ? late_ms_reg : head.silence;
    assign kick_now  = kicking_en_reg && !late_any && hw_wdt_running;

    always_comb begin
        cnt_next        = cnt_reg;
        id_next         = id_reg;
        late_seen_next  = late_seen_reg;
        late_id_next    = late_id_reg;
        late_ms_next    = late_ms_reg;
        kicking_en_next = kicking_en_reg;
        kick_cnt_next   = kick_cnt_reg;
        if (out_acc) begin
            cnt_next = cnt_reg - CNT_W'(1);
            id_next  = id_reg + 2'd1;
            if (head_late) begin
                late_seen_next = 1'b1;
                late_id_next   = id_reg;
                late_ms_next   = head.silence;
            end
            if (last) begin
                kick_cnt_next = kick_cnt_reg + {31'd0, kick_now};
                if (late_any) begin
                    kicking_en_next = 1'b0;
                end
            end
        end
        if (do_check) begin
            cnt_next       = CNT_W'(NUM_CLIENTS);
            id_next        = 2'd0;
            late_seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            id_reg         <= '0;
            late_seen_reg  <= 1'b0;
            kicking_en_reg <= 1'b1;
            kick_cnt_reg   <= '0;
        end else begin
            cnt_reg        <= cnt_next;
            id_reg         <= id_next;
            late_seen_reg  <= late_seen_next;
            kicking_en_reg <= kicking_en_next;
            kick_cnt_reg   <= kick_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        late_id_reg <= late_id_next;
        late_ms_reg <= late_ms_next;
    end

    assign m_client_id   = id_reg;
    assign m_silence_ms  = head.silence;
    assign m_worst_ms    = head.worst;
    assign m_over_limit  = head.over;
    assign m_last_of_run = last;
    assign m_kick        = last && kick_now;
    assign m_report_late = last && kicking_en_reg && late_any;
    assign m_late_client = (last && late_any) ? late_id : mcws_pkg::NO_LATE;
    assign m_late_ms     = (last && late_any) ? late_val : '0;
    assign m_kicking_on  = last ? (kicking_en_reg && !late_any) : kicking_en_reg;
    assign m_kick_total  = kick_cnt_reg + {31'd0, (last && kick_now)};

`ifndef SYNTHESIS
    a_last_is_final_client: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_run) |-> (m_client_id == 2'(NUM_CLIENTS - 1)))
        else $error("last result of a check does not describe the final client");

    a_kicking_stays_off: assert property (@(posedge aclk) disable iff (!aresetn)
        !kicking_en_reg |=> !kicking_en_reg)
        else $error("kicking was enabled again after it stopped");

    a_kick_count_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        !(out_acc && last) |=> $stable(kick_cnt_reg))
        else $error("kick counter changed outside the end of a check");

    a_no_request_mid_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy && !(m_ready && last)) |-> !s_ready)
        else $error("request taken while check results are still pending");
`endif

endmodule

// ===== rtl/mcws_regs.sv =====
module mcws_regs (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [mcws_pkg::PADDR_W-1:0]              paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready,
    output mcws_pkg::word_t [mcws_pkg::NUM_LIMITS-1:0] limit,
    output logic                                      hw_wdt_running
);

    mcws_pkg::word_t [mcws_pkg::NUM_LIMITS-1:0] limit_reg, limit_next;
    logic                                        hw_wdt_reg, hw_wdt_next;
    logic                                        wr_en;
    logic [1:0]                                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        limit_next  = limit_reg;
        hw_wdt_next = hw_wdt_reg;
        if (wr_en) begin
            unique case (reg_idx)
                mcws_pkg::REG_LIMIT_0: limit_next[0] = pwdata;
                mcws_pkg::REG_LIMIT_1: limit_next[1] = pwdata;
                mcws_pkg::REG_LIMIT_2: limit_next[2] = pwdata;
                mcws_pkg::REG_HW_WDT:  hw_wdt_next   = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= {mcws_pkg::NUM_LIMITS{mcws_pkg::LIMIT_RESET}};
            hw_wdt_reg <= 1'b1;
        end else begin
            limit_reg  <= limit_next;
            hw_wdt_reg <= hw_wdt_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            mcws_pkg::REG_LIMIT_0: prdata = limit_reg[0];
            mcws_pkg::REG_LIMIT_1: prdata = limit_reg[1];
            mcws_pkg::REG_LIMIT_2: prdata = limit_reg[2];
            mcws_pkg::REG_HW_WDT:  prdata = {31'd0, hw_wdt_reg};
        endcase
    end

    assign limit          = limit_reg;
    assign hw_wdt_running = hw_wdt_reg;

endmodule

// ===== rtl/mcws_cell.sv =====
module mcws_cell #(
    parameter int unsigned TICK_RATE_HZ = mcws_pkg::TICK_RATE_HZ_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mcws_pkg::cell_ctrl_t ctrl,
    input  logic                 checkin,
    input  mcws_pkg::word_t      limit,
    input  mcws_pkg::slot_t      slot_in,
    output mcws_pkg::slot_t      slot_out
);

    // The silence in ms is kept as quotient and remainder of ticks*1000/rate,
    // so each tick adds a constant step instead of dividing.
    localparam int unsigned REM_W = (TICK_RATE_HZ > 1) ? $clog2(TICK_RATE_HZ) : 1;
    localparam int unsigned SUM_W = REM_W + 1;
    localparam mcws_pkg::word_t  STEP_Q = 32'(mcws_pkg::MS_PER_S / TICK_RATE_HZ);
    localparam logic [SUM_W-1:0] STEP_R = SUM_W'(mcws_pkg::MS_PER_S % TICK_RATE_HZ);
    localparam logic [SUM_W-1:0] RATE   = SUM_W'(TICK_RATE_HZ);

    mcws_pkg::word_t  ticks_reg, ticks_next;
    mcws_pkg::word_t  ms_reg, ms_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    mcws_pkg::word_t  worst_reg, worst_next;
    mcws_pkg::slot_t  slot_reg, slot_next;

    logic [SUM_W-1:0] rem_sum;
    logic [SUM_W-1:0] rem_fix;
    logic             rem_carry;
    mcws_pkg::word_t  ms_step;
    mcws_pkg::word_t  worst_upd;

    assign rem_sum   = {1'b0, rem_reg} + STEP_R;
    assign rem_carry = (rem_sum >= RATE);
    assign rem_fix   = rem_carry ? (rem_sum - RATE) : rem_sum;
    assign ms_step   = ms_reg + STEP_Q + {31'd0, rem_carry};
    assign worst_upd = (ms_reg > worst_reg) ? ms_reg : worst_reg;

    always_comb begin
        ticks_next = ticks_reg;
        ms_next    = ms_reg;
        rem_next   = rem_reg;
        // A check-in, or the tick difference wrapping to zero, restarts the count.
        if (checkin || (ctrl.tick && (ticks_reg == '1))) begin
            ticks_next = '0;
            ms_next    = '0;
            rem_next   = '0;
        end else if (ctrl.tick) begin
            ticks_next = ticks_reg + 32'd1;
            ms_next    = ms_step;
            rem_next   = rem_fix[REM_W-1:0];
        end
    end

    always_comb begin
        worst_next = worst_reg;
        slot_next  = slot_reg;
        if (ctrl.load) begin
            worst_next        = worst_upd;
            slot_next.silence = ms_reg;
            slot_next.worst   = worst_upd;
            slot_next.over    = (ms_reg > limit);
        end else if (ctrl.shift) begin
            slot_next = slot_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= '0;
            ms_reg    <= '0;
            rem_reg   <= '0;
            worst_reg <= '0;
        end else begin
            ticks_reg <= ticks_next;
            ms_reg    <= ms_next;
            rem_reg   <= rem_next;
            worst_reg <= worst_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

// ===== test/multi_client_watchdog_supervisor_checker.sv =====
module multi_client_watchdog_supervisor_checker
    import mcws_pkg::*;
#(
    parameter int unsigned NUM_CLIENTS  = NUM_CLIENTS_DEF,
    parameter int unsigned TICK_RATE_HZ = TICK_RATE_HZ_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [1:0]          s_client_index,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [1:0]          m_client_id,
    input  logic [31:0]         m_silence_ms,
    input  logic [31:0]         m_worst_ms,
    input  logic                m_over_limit,
    input  logic                m_kick,
    input  logic                m_report_late,
    input  logic [1:0]          m_late_client,
    input  logic [31:0]         m_late_ms,
    input  logic                m_kicking_on,
    input  logic [31:0]         m_kick_total,
    input  logic                m_last_of_run,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,

    output int                  fail_count,
    output int                  pending,
    output int                  checked
);

    typedef struct packed {
        logic [1:0] client_id;
        word_t      silence;
        word_t      worst_ms;
        logic       over_limit;
        logic       kick;
        logic       report_late;
        logic [1:0] late_id;
        word_t      late_ms;
        logic       kicking_on;
        word_t      kick_total;
        logic       last_of_run;
    } client_report_t;

    client_report_t expected_reports[$];

    // Shadow copy of the registers and of the supervisor state.
    word_t limit_shadow [NUM_LIMITS];
    logic  wdt_running;
    word_t tick_count;
    word_t last_checkin [NUM_LIMITS];
    word_t worst_seen   [NUM_LIMITS];
    logic  kick_enable;
    word_t kicks_issued;

    // Walks every client the way a periodic check does and queues one report
    // per client; the last one carries the kick decision.
    task automatic run_check();
        client_report_t rpt;
        client_report_t closing;
        word_t          diff;
        logic [63:0]    scaled;
        word_t          silence;
        logic [1:0]     first_late;
        word_t          first_late_ms;
        first_late    = NO_LATE;
        first_late_ms = '0;
        closing       = '0;
        for (int i = 0; i < NUM_CLIENTS; i++) begin
            diff    = tick_count - last_checkin[i];
            scaled  = {32'd0, diff} * MS_PER_S;
            scaled  = scaled / TICK_RATE_HZ;
            silence = scaled[31:0];
            if (silence > worst_seen[i]) begin
                worst_seen[i] = silence;
            end
            rpt             = '0;
            rpt.client_id   = i[1:0];
            rpt.silence     = silence;
            rpt.worst_ms    = worst_seen[i];
            rpt.over_limit  = silence > limit_shadow[i];
            rpt.late_id     = NO_LATE;
            rpt.kicking_on  = kick_enable;
            rpt.kick_total  = kicks_issued;
            if (rpt.over_limit && first_late == NO_LATE) begin
                first_late    = i[1:0];
                first_late_ms = silence;
            end
            if (i == NUM_CLIENTS - 1) begin
                closing = rpt;
            end else begin
                expected_reports.push_back(rpt);
            end
        end
        if (kick_enable) begin
            if (first_late == NO_LATE) begin
                if (wdt_running) begin
                    kicks_issued = kicks_issued + 1;
                    closing.kick = 1'b1;
                end
            end else begin
                kick_enable         = 1'b0;
                closing.report_late = 1'b1;
            end
        end
        closing.late_id     = first_late;
        closing.late_ms     = first_late_ms;
        closing.kicking_on  = kick_enable;
        closing.kick_total  = kicks_issued;
        closing.last_of_run = 1'b1;
        expected_reports.push_back(closing);
    endtask

    task automatic compare_field(input string field, input word_t want, input word_t got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Everything is sampled on the falling edge, where the values that the
    // next rising edge will see are already settled.
    always @(negedge aclk) begin : watch
        client_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_LIMITS; i++) begin
                limit_shadow[i] = LIMIT_RESET;
                last_checkin[i] = '0;
                worst_seen[i]   = '0;
            end
            wdt_running  = 1'b1;
            tick_count   = '0;
            kick_enable  = 1'b1;
            kicks_issued = '0;
            fail_count   = 0;
            checked      = 0;
            expected_reports.delete();
        end else begin
            // Results are compared before the request of this cycle is
            // predicted, so a result can never match its own request early.
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual client %0d",
                             $time, m_client_id);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    checked++;
                    compare_field("client_id",   want.client_id,   m_client_id);
                    compare_field("silence",     want.silence,     m_silence_ms);
                    compare_field("worst_ms",    want.worst_ms,    m_worst_ms);
                    compare_field("over_limit",  want.over_limit,  m_over_limit);
                    compare_field("kick",        want.kick,        m_kick);
                    compare_field("report_late", want.report_late, m_report_late);
                    compare_field("late_id",     want.late_id,     m_late_client);
                    compare_field("late_ms",     want.late_ms,     m_late_ms);
                    compare_field("kicking_on",  want.kicking_on,  m_kicking_on);
                    compare_field("kick_total",  want.kick_total,  m_kick_total);
                    compare_field("last_of_run", want.last_of_run, m_last_of_run);
                end
            end
            if (s_valid && s_ready) begin
                case (s_cmd)
                    CMD_TICK: begin
                        tick_count = tick_count + 1;
                    end
                    CMD_CHECKIN: begin
                        if (s_client_index < NUM_CLIENTS) begin
                            last_checkin[s_client_index] = tick_count;
                        end
                    end
                    CMD_CHECK: begin
                        run_check();
                    end
                    default: begin
                    end
                endcase
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LIMIT_0: limit_shadow[0] = pwdata;
                    REG_LIMIT_1: limit_shadow[1] = pwdata;
                    REG_LIMIT_2: limit_shadow[2] = pwdata;
                    REG_HW_WDT:  wdt_running     = pwdata[0];
                    default: begin
                    end
                endcase
            end
        end
        pending = expected_reports.size();
    end

endmodule

// ===== test/multi_client_watchdog_supervisor_top_test.sv =====
module multi_client_watchdog_supervisor_top_test;

    import mcws_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 6;
    localparam int PHASE_REQUESTS  = 60;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;

    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd          = CMD_TICK;
    logic [1:0]         s_client_index = 2'd0;

    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [1:0]         m_client_id;
    logic [31:0]        m_silence_ms;
    logic [31:0]        m_worst_ms;
    logic               m_over_limit;
    logic               m_kick;
    logic               m_report_late;
    logic [1:0]         m_late_client;
    logic [31:0]        m_late_ms;
    logic               m_kicking_on;
    logic [31:0]        m_kick_total;
    logic               m_last_of_run;

    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    int  fail_count;
    int  pending;
    int  checked;

    bit  calm          = 1'b0;
    bit  hold_off_go   = 1'b0;
    bit  hold_off_used = 1'b0;
    int  hold_left     = 0;
    int  cycle_count   = 0;
    int  requests_sent = 0;
    int  writes_done   = 0;

    multi_client_watchdog_supervisor_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_client_index (s_client_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_client_id    (m_client_id),
        .m_silence_ms   (m_silence_ms),
        .m_worst_ms     (m_worst_ms),
        .m_over_limit   (m_over_limit),
        .m_kick         (m_kick),
        .m_report_late  (m_report_late),
        .m_late_client  (m_late_client),
        .m_late_ms      (m_late_ms),
        .m_kicking_on   (m_kicking_on),
        .m_kick_total   (m_kick_total),
        .m_last_of_run  (m_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    multi_client_watchdog_supervisor_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_client_index (s_client_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_client_id    (m_client_id),
        .m_silence_ms   (m_silence_ms),
        .m_worst_ms     (m_worst_ms),
        .m_over_limit   (m_over_limit),
        .m_kick         (m_kick),
        .m_report_late  (m_report_late),
        .m_late_client  (m_late_client),
        .m_late_ms      (m_late_ms),
        .m_kicking_on   (m_kicking_on),
        .m_kick_total   (m_kick_total),
        .m_last_of_run  (m_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     CYCLE_LIMIT, pending);
            $display("multi_client_watchdog_supervisor_top_test NOT OK");
            $finish;
        end
    end

    // Result side: random back-pressure, none during the calm phase, and one
    // long hold-off that lets the block fill up and stall its request input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_go && !hold_off_used) begin
            m_ready       <= 1'b0;
            hold_left     <= HOLD_OFF_CYCLES;
            hold_off_used <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [1:0] index);
        bit taken;
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_client_index <= index;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        requests_sent++;
    endtask

    task automatic send_random_request();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_request(CMD_TICK, 2'($urandom_range(0, 3)));
        end else if (pick < 72) begin
            send_request(CMD_CHECKIN, 2'($urandom_range(0, 3)));
        end else if (pick < 95) begin
            send_request(CMD_CHECK, 2'($urandom_range(0, 3)));
        end else begin
            send_request(CMD_NONE, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input word_t value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        writes_done++;
    endtask

    // Waits until every queued result is out, then waits on for a settle time so
    // that a tick or check-in still in flight has landed.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic word_t small_limit();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 40);
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers: every client is on time, so each check kicks.
        send_request(CMD_CHECK, 2'd0);
        send_request(CMD_NONE, 2'd3);
        send_request(CMD_TICK, 2'd0);
        send_request(CMD_TICK, 2'd2);
        send_request(CMD_CHECKIN, 2'd1);
        send_request(CMD_CHECKIN, 2'd3);
        send_request(CMD_TICK, 2'd1);
        send_request(CMD_CHECK, 2'd1);
        settle();

        // With the hardware watchdog stopped a check must not kick.
        write_reg(REG_HW_WDT, 32'd0);
        write_reg(REG_LIMIT_0, 32'hFFFF_FFFF);
        write_reg(REG_LIMIT_1, 32'hFFFF_FFFF);
        write_reg(REG_LIMIT_2, 32'hFFFF_FFFF);
        send_request(CMD_CHECKIN, 2'd0);
        send_request(CMD_TICK, 2'd3);
        send_request(CMD_CHECK, 2'd2);
        settle();

        write_reg(REG_HW_WDT, 32'd1);
        send_request(CMD_CHECKIN, 2'd2);
        send_request(CMD_CHECK, 2'd3);
        settle();

        // The first phases keep the limits high so no client goes late; from
        // the fourth on they are small, a client goes late and kicking stops.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                write_reg(REG_LIMIT_0, $urandom_range(32'hFFFF_FFFF, 5000));
                write_reg(REG_LIMIT_1, $urandom_range(32'hFFFF_FFFF, 5000));
                write_reg(REG_LIMIT_2, $urandom_range(32'hFFFF_FFFF, 5000));
            end else begin
                write_reg(REG_LIMIT_0, (phase == 3) ? 32'd0 : small_limit());
                write_reg(REG_LIMIT_1, small_limit());
                write_reg(REG_LIMIT_2, small_limit());
            end
            write_reg(REG_HW_WDT, (phase == 0) ? 32'd1 : $urandom);
            calm <= (phase == 1);
            if (phase == 2) begin
                hold_off_go <= 1'b1;
            end
            repeat (PHASE_REQUESTS) send_random_request();
            settle();
        end

        $display("Sent %0d requests, checked %0d results, made %0d register writes.",
                 requests_sent, checked, writes_done);
        $display("%s", {"Covered kicks with the watchdog on and off, a late-client shutdown, ",
                        "a calm stretch and a long result hold-off."});
        if (fail_count == 0) begin
            $display("multi_client_watchdog_supervisor_top_test OK");
        end else begin
            $display("multi_client_watchdog_supervisor_top_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mcws_pkg.sv
rtl/mcws_regs.sv
rtl/mcws_cell.sv
rtl/multi_client_watchdog_supervisor_top.sv
test/multi_client_watchdog_supervisor_checker.sv
test/multi_client_watchdog_supervisor_top_test.sv
